### hw/rtl/fbpe_pkg.sv
// shared types and constants of the page framebuffer pixel engine
// no dependencies; imported by every module of the block
package fbpe_pkg;

   localparam int BUF_DEPTH = 512;
   localparam int BUF_AW    = 9;
   localparam int CSR_AW    = 3;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   localparam logic CSR_ROTATION = 1'b0;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_SET    = 2'd1,
      OP_INVERT = 2'd2,
      OP_KEEP   = 2'd3
   } colour_op_type;

   typedef enum logic [1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rot_type;

   typedef enum logic {
      ST_CLEAR = 1'b0,
      ST_RUN   = 1'b1
   } buf_state_type;

   // one buffer access after clipping and rotation
   typedef struct packed {
      logic                valid;
      logic                is_read;
      logic [BUF_AW-1:0]   addr;
      logic [7:0]          mask;
      colour_op_type       op;
      logic                clipped;
   } access_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] read_data;
      logic       clipped;
   } result_type;

endpackage

### hw/rtl/mono_page_framebuffer_pixel_engine.sv
// monochrome page framebuffer pixel engine, top level
// results pass through the stage 1 and result registers; one item per cycle sustained
// throughput set by the buffer memory doing one read and one write back each cycle
// reset: rotation goes to 0, buffer cleared by a sweep over all 512 bytes (one byte a cycle)
// busy stays high during reset and the sweep; results cannot be stalled by the receiver
// depends on fbpe_pkg, fbpe_xform, fbpe_buffer
module mono_page_framebuffer_pixel_engine
   import fbpe_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic signed [8:0]  req_pixel_x,
   input  logic signed [8:0]  req_pixel_y,
   input  logic [1:0]         req_colour_op,
   input  logic [BUF_AW-1:0]  req_byte_index,
   // result channel, one-cycle strobe
   output logic               rsp_valid,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_clipped,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic        buf_ready;
   logic        accept;
   logic [1:0]  rotation_ff, rotation_in;
   logic        csr_wr;
   access_type  access;
   result_type  result;

   // register port: rotation at byte addresses 0 to 3 (paddr[2] low), addresses 4 to 7 read zero
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      rotation_in = rotation_ff;
      if (csr_wr && paddr[2] == CSR_ROTATION) begin
         rotation_in = pwdata[1:0];
      end
      prdata = (paddr[2] == CSR_ROTATION) ? {30'd0, rotation_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= 2'd0;
      end else begin
         rotation_ff <= rotation_in;
      end
   end

   // request transfer when start meets an idle engine
   assign busy   = reset || !buf_ready;
   assign accept = start && !busy;

   // clipping against the rotated logical screen, then panel address and bit mask
   fbpe_xform #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_xform (
      .accept     (accept),
      .rotation   (rot_type'(rotation_ff)),
      .req_type   (req_type),
      .pixel_x    (req_pixel_x),
      .pixel_y    (req_pixel_y),
      .colour_op  (colour_op_type'(req_colour_op)),
      .byte_index (req_byte_index),
      .access     (access)
   );

   // memory read at the transfer edge, modify and write back in the following cycle
   fbpe_buffer u_buffer (
      .clock  (clock),
      .reset  (reset),
      .access (access),
      .ready  (buf_ready),
      .result (result)
   );

   assign rsp_valid     = result.valid;
   assign rsp_read_data = result.read_data;
   assign rsp_clipped   = result.clipped;

   // every result strobe comes from a request transfer through the stage 1 and result registers
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result strobe without matching request transfer");

   // a dropped write never reports buffer data
   a_clip_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |-> (rsp_read_data == 8'd0))
      else $error("clipped result carries data");

   // the clear sweep holds off requests right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("engine ready before buffer clear");

endmodule

### hw/rtl/fbpe_xform.sv
// clip, rotate and byte/bit address mapping of one request
// depends on fbpe_pkg
module fbpe_xform
   import fbpe_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic               accept,
   input  rot_type            rotation,
   input  logic               req_type,
   input  logic signed [8:0]  pixel_x,
   input  logic signed [8:0]  pixel_y,
   input  colour_op_type      colour_op,
   input  logic [BUF_AW-1:0]  byte_index,
   output access_type         access
);

   localparam logic [8:0]  WIDTH_C  = 9'(SCREEN_WIDTH);
   localparam logic [8:0]  HEIGHT_C = 9'(SCREEN_HEIGHT);
   localparam logic [8:0]  W_M1     = 9'(SCREEN_WIDTH - 1);
   localparam logic [8:0]  H_M1     = 9'(SCREEN_HEIGHT - 1);
   localparam logic [10:0] STRIDE   = 11'(SCREEN_WIDTH);

   logic [8:0]  lw, lh;
   logic        x_in, y_in;
   logic [8:0]  xu, yu, px, py;
   logic [10:0] lin_addr;

   always_comb begin
      // logical size swaps for quarter turns
      lw = rotation[0] ? HEIGHT_C : WIDTH_C;
      lh = rotation[0] ? WIDTH_C  : HEIGHT_C;
      xu = {1'b0, pixel_x[7:0]};
      yu = {1'b0, pixel_y[7:0]};
      x_in = !pixel_x[8] && (xu < lw);
      y_in = !pixel_y[8] && (yu < lh);

      unique case (rotation)
         ROT_90: begin
            px = W_M1 - yu;
            py = xu;
         end
         ROT_180: begin
            px = W_M1 - xu;
            py = H_M1 - yu;
         end
         ROT_270: begin
            px = yu;
            py = H_M1 - xu;
         end
         default: begin
            px = xu;
            py = yu;
         end
      endcase

      // page stride times page plus column, wraps at buffer depth
      lin_addr = STRIDE * {8'd0, py[5:3]} + {3'd0, px[7:0]};

      access.valid   = accept;
      access.is_read = (req_type == REQ_READ);
      access.addr    = (req_type == REQ_READ) ? byte_index : lin_addr[BUF_AW-1:0];
      access.mask    = 8'd1 << py[2:0];
      access.op      = colour_op;
      access.clipped = (req_type == REQ_PIXEL) && !(x_in && y_in);
   end

endmodule

### hw/rtl/fbpe_buffer.sv
// page buffer memory with read-modify-write, forwarding and clear sweep
// depends on fbpe_pkg
module fbpe_buffer
   import fbpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  access_type  access,
   output logic        ready,
   output result_type  result
);

   logic [7:0] mem [BUF_DEPTH];

   buf_state_type      state_ff, state_in;
   logic [BUF_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   access_type         s1_ff;
   logic [7:0]         rd_ff;
   logic               last_vld_ff;
   logic [BUF_AW-1:0]  last_addr_ff;
   logic [7:0]         last_data_ff;
   result_type         res_ff, res_in;

   logic [7:0]         old_byte, new_byte;
   logic               upd_en, wr_en;
   logic [BUF_AW-1:0]  wr_addr;
   logic [7:0]         wr_data;

   // clear sweep after reset, then normal operation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      ready      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == BUF_AW'(BUF_DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            ready = 1'b1;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // stage 1: byte from memory, or the write of the previous cycle
   always_comb begin
      old_byte = (last_vld_ff && last_addr_ff == s1_ff.addr) ? last_data_ff : rd_ff;
      unique case (s1_ff.op)
         OP_CLEAR:  new_byte = old_byte & ~s1_ff.mask;
         OP_SET:    new_byte = old_byte | s1_ff.mask;
         OP_INVERT: new_byte = old_byte ^ s1_ff.mask;
         default:   new_byte = old_byte;
      endcase
      upd_en = s1_ff.valid && !s1_ff.is_read && !s1_ff.clipped && (s1_ff.op != OP_KEEP);
      wr_en   = (state_ff == ST_CLEAR) || upd_en;
      wr_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : s1_ff.addr;
      wr_data = (state_ff == ST_CLEAR) ? 8'd0 : new_byte;

      res_in.valid     = s1_ff.valid;
      res_in.read_data = s1_ff.is_read ? old_byte : 8'd0;
      res_in.clipped   = s1_ff.clipped;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[access.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         last_vld_ff  <= 1'b0;
         res_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid  <= access.valid;
         last_vld_ff  <= upd_en;
         res_ff.valid <= res_in.valid;
      end
      s1_ff.is_read    <= access.is_read;
      s1_ff.addr       <= access.addr;
      s1_ff.mask       <= access.mask;
      s1_ff.op         <= access.op;
      s1_ff.clipped    <= access.clipped;
      last_addr_ff     <= s1_ff.addr;
      last_data_ff     <= new_byte;
      res_ff.read_data <= res_in.read_data;
      res_ff.clipped   <= res_in.clipped;
   end

   assign result = res_ff;

endmodule

### test/tb_mono_page_framebuffer_pixel_engine.sv
// self-checking testbench for the monochrome page framebuffer pixel engine
// predicts every result from its own copy of the page buffer and rotation register
// depends on fbpe_pkg and mono_page_framebuffer_pixel_engine
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_pixel_engine;
   import fbpe_pkg::*;

   localparam int SCR_W         = 128;
   localparam int SCR_H         = 32;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS   = 10;

   // one command as the drawing side sees it
   typedef struct {
      logic                kind;
      logic signed [8:0]   x;
      logic signed [8:0]   y;
      colour_op_type       op;
      logic [BUF_AW-1:0]   index;
   } pixel_cmd_type;

   // what the engine must answer for one command
   typedef struct {
      logic [7:0] read_data;
      logic       clipped;
   } pixel_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_type;
   logic signed [8:0]  req_pixel_x;
   logic signed [8:0]  req_pixel_y;
   logic [1:0]         req_colour_op;
   logic [BUF_AW-1:0]  req_byte_index;
   logic               rsp_valid;
   logic [7:0]         rsp_read_data;
   logic               rsp_clipped;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [CSR_AW-1:0]  paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   // shadow of the panel memory and the rotation register
   logic [7:0]          frame_mem [BUF_DEPTH];
   rot_type             cur_rotation;
   logic [BUF_AW-1:0]   last_write_addr;

   // results still owed by the engine, oldest first
   pixel_result_type    pending [$];
   int                  mismatch_count;
   int                  cycle_count;

   mono_page_framebuffer_pixel_engine #(
      .SCREEN_WIDTH  (SCR_W),
      .SCREEN_HEIGHT (SCR_H)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .req_colour_op  (req_colour_op),
      .req_byte_index (req_byte_index),
      .rsp_valid      (rsp_valid),
      .rsp_read_data  (rsp_read_data),
      .rsp_clipped    (rsp_clipped),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop if the engine hangs or loses results
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending.size());
         $display("tb_mono_page_framebuffer_pixel_engine: FAIL");
         $finish;
      end
   end

   task automatic note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // clip, rotate and apply one command to the shadow memory
   function automatic pixel_result_type apply_pixel_cmd(pixel_cmd_type c);
      pixel_result_type   res;
      int                 x, y, lw, lh, col, row;
      logic [BUF_AW-1:0]  addr;
      logic [7:0]         mask;
      res.read_data = 8'd0;
      res.clipped   = 1'b0;
      if (c.kind == REQ_READ) begin
         res.read_data = frame_mem[c.index];
         return res;
      end
      x = c.x;
      y = c.y;
      // quarter turns swap the logical width and height
      lw = cur_rotation[0] ? SCR_H : SCR_W;
      lh = cur_rotation[0] ? SCR_W : SCR_H;
      if (x < 0 || x >= lw || y < 0 || y >= lh) begin
         res.clipped = 1'b1;
         return res;
      end
      case (cur_rotation)
         ROT_90: begin
            col = SCR_W - 1 - y;
            row = x;
         end
         ROT_180: begin
            col = SCR_W - 1 - x;
            row = SCR_H - 1 - y;
         end
         ROT_270: begin
            col = y;
            row = SCR_H - 1 - x;
         end
         default: begin
            col = x;
            row = y;
         end
      endcase
      // page of 8 rows per byte, address wraps at the buffer size
      addr = BUF_AW'(SCR_W * (row / 8) + col);
      mask = 8'd1 << (row % 8);
      case (c.op)
         OP_CLEAR:  frame_mem[addr] = frame_mem[addr] & ~mask;
         OP_SET:    frame_mem[addr] = frame_mem[addr] | mask;
         OP_INVERT: frame_mem[addr] = frame_mem[addr] ^ mask;
         default: ;
      endcase
      last_write_addr = addr;
      return res;
   endfunction

   function automatic pixel_cmd_type pixel_write(int x, int y, colour_op_type op);
      pixel_cmd_type c;
      c.kind  = REQ_PIXEL;
      c.x     = 9'(x);
      c.y     = 9'(y);
      c.op    = op;
      c.index = BUF_AW'($urandom);
      return c;
   endfunction

   function automatic pixel_cmd_type byte_read(int index);
      pixel_cmd_type c;
      c.kind  = REQ_READ;
      c.x     = 9'(0);
      c.y     = 9'(0);
      c.op    = OP_KEEP;
      c.index = BUF_AW'(index);
      return c;
   endfunction

   // coordinates biased to the screen edges, the corner box and just outside
   function automatic int pick_coord(int limit);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return -1;
      if (r < 10) return limit;
      if (r < 20) return limit - 1;
      if (r < 25) return 0;
      if (r < 50) return $urandom_range(0, 15);
      return $urandom_range(0, limit - 1);
   endfunction

   function automatic pixel_cmd_type make_random_cmd();
      pixel_cmd_type c;
      int            r;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         // refresh reads, half of them on the byte touched last
         c = byte_read($urandom_range(0, BUF_DEPTH - 1));
         if ($urandom_range(0, 1))
            c.index = last_write_addr;
      end else if (r < 33) begin
         // raw 9-bit coordinates, mostly clipped
         c = pixel_write(0, 0, colour_op_type'($urandom_range(0, 3)));
         c.x = 9'($urandom);
         c.y = 9'($urandom);
      end else begin
         c = pixel_write(pick_coord(cur_rotation[0] ? SCR_H : SCR_W),
                         pick_coord(cur_rotation[0] ? SCR_W : SCR_H),
                         colour_op_type'($urandom_range(0, 3)));
      end
      return c;
   endfunction

   // present one command from a falling edge and hold it until the transfer
   task automatic send_cmd(pixel_cmd_type c);
      start          = 1'b1;
      req_type       = c.kind;
      req_pixel_x    = c.x;
      req_pixel_y    = c.y;
      req_colour_op  = c.op;
      req_byte_index = c.index;
      do @(posedge clock); while (busy);
      pending.push_back(apply_pixel_cmd(c));
      @(negedge clock);
   endtask

   // mostly back to back, some short gaps, a few long ones
   task automatic idle_gap(bit random_gaps);
      int r, n;
      if (!random_gaps) return;
      r = $urandom_range(0, 99);
      if (r < 60) n = 0;
      else if (r < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      if (n == 0) return;
      start = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_results_drained();
      start = 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // register write then read-back, only with the engine idle
   task automatic write_rotation(rot_type rot);
      wait_results_drained();
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_AW'({CSR_ROTATION, 2'b00});
      pwdata  = 32'(rot);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      cur_rotation = rot;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(rot))
         note_mismatch($sformatf("rotation read-back expected %08h actual %08h",
                                 32'(rot), prdata));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic apply_reset();
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // buffer clearing sweep keeps busy high
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // corners, every colour op, invert twice, keep, clipping on each side
   task automatic test_directed_corners();
      pixel_cmd_type cmds [$];
      cmds.push_back(byte_read(0));
      cmds.push_back(byte_read(BUF_DEPTH - 1));
      cmds.push_back(pixel_write(0, 0, OP_SET));
      cmds.push_back(pixel_write(SCR_W - 1, SCR_H - 1, OP_SET));
      cmds.push_back(byte_read(0));
      cmds.push_back(byte_read(BUF_DEPTH - 1));
      cmds.push_back(pixel_write(0, 0, OP_INVERT));
      cmds.push_back(byte_read(0));
      cmds.push_back(pixel_write(0, 0, OP_INVERT));
      cmds.push_back(pixel_write(5, 9, OP_SET));
      cmds.push_back(pixel_write(5, 9, OP_KEEP));
      cmds.push_back(byte_read(SCR_W + 5));
      cmds.push_back(pixel_write(SCR_W - 1, SCR_H - 1, OP_CLEAR));
      cmds.push_back(byte_read(BUF_DEPTH - 1));
      cmds.push_back(pixel_write(-1, 0, OP_SET));
      cmds.push_back(pixel_write(SCR_W, 0, OP_SET));
      cmds.push_back(pixel_write(0, SCR_H, OP_SET));
      cmds.push_back(pixel_write(-256, -256, OP_SET));
      cmds.push_back(pixel_write(255, 255, OP_INVERT));
      cmds.push_back(pixel_write(0, -1, OP_CLEAR));
      cmds.push_back(byte_read(0));
      foreach (cmds[i])
         send_cmd(cmds[i]);
   endtask

   task automatic test_rotation_phase(rot_type rot, int count, bit random_gaps);
      write_rotation(rot);
      repeat (count) begin
         send_cmd(make_random_cmd());
         idle_gap(random_gaps);
      end
   endtask

   // a burst, a full stop until every result is back, then another burst
   task automatic test_pause_and_resume(int count);
      repeat (count) send_cmd(make_random_cmd());
      wait_results_drained();
      repeat (count) begin
         send_cmd(make_random_cmd());
         idle_gap(1'b1);
      end
   endtask

   // each strobed result is matched against the oldest expectation
   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_valid) begin
         if (pending.size() == 0) begin
            note_mismatch($sformatf("result with nothing expected: data %02h clipped %0b",
                                    rsp_read_data, rsp_clipped));
         end else begin
            want = pending.pop_front();
            if (rsp_read_data !== want.read_data)
               note_mismatch($sformatf("read_data expected %02h actual %02h",
                                       want.read_data, rsp_read_data));
            if (rsp_clipped !== want.clipped)
               note_mismatch($sformatf("clipped expected %0b actual %0b",
                                       want.clipped, rsp_clipped));
         end
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_type       = REQ_PIXEL;
      req_pixel_x    = '0;
      req_pixel_y    = '0;
      req_colour_op  = OP_KEEP;
      req_byte_index = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      cur_rotation   = ROT_0;
      last_write_addr = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      foreach (frame_mem[i])
         frame_mem[i] = 8'd0;

      apply_reset();
      test_directed_corners();
      test_rotation_phase(ROT_90, 160, 1'b0);
      test_rotation_phase(ROT_270, 160, 1'b1);
      test_rotation_phase(ROT_180, 160, 1'b1);
      test_rotation_phase(ROT_0, 160, 1'b0);
      test_pause_and_resume(30);
      test_rotation_phase(rot_type'($urandom_range(0, 3)), 110, 1'b1);
      test_rotation_phase(rot_type'($urandom_range(0, 3)), 110, 1'b1);

      // let the last transfers come back before the verdict
      wait_results_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_mono_page_framebuffer_pixel_engine: PASS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_mono_page_framebuffer_pixel_engine: FAIL");
      end
      $finish;
   end

endmodule
